// ===== sv/bmh_pkg.sv =====
// Shared types and codes for the binary max-heap table.
// Used by the top level binary_max_heap_table; depends on nothing else.
package bmh_pkg;

   typedef logic signed [31:0] value_type;

   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_DELETE = 2'd1,
      ACT_READ   = 2'd2,
      ACT_NOP    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

endpackage

// ===== sv/bmh_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
// Holds the heap entries for binary_max_heap_table; no package dependency.
module bmh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ===== sv/binary_max_heap_table.sv =====
// Binary max-heap table: request channel, result channel and heap sequencer.
// Depends on bmh_pkg and on bmh_ram, which holds the entries.
//
// Usage: an item on the req_ channel carries an action (insert, delete all
// entries equal to the value, or read the entry at an index), a signed value
// and an index. Every item yields exactly one item on the rsp_ channel with the
// status, the entry read, the count now held and the number removed.
// One item is worked on at a time by a sequencer around a single RAM with one
// write port and one registered read port; req_stall is low only while the
// sequencer is idle.
// Steps: a refused, out-of-range or no-op item goes straight to the result
// register, and a read first fetches its entry from the RAM. An insert climbs
// a level per parent compare until the new entry stops. A delete checks each
// slot in turn, and the slot that took the last entry is checked again; each
// removal fetches the last entry, unless the match was in the last slot, and
// sifts it up or down, so its cost grows with the count held and the
// number of matches.
// The next item is taken the cycle after a result is registered.
// The result register frees the request side: a new item is taken while a
// result still waits under rsp_stall, and the sequencer holds its finished
// result until the register drains.
// Reset (synchronous, active high) empties the table; the RAM is not cleared,
// as no entry beyond the count is ever read.
module binary_max_heap_table #(
   parameter int CAPACITY = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_action,
   input  bmh_pkg::value_type req_value,
   input  logic [5:0]         req_index,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output bmh_pkg::value_type rsp_entry_value,
   output logic [6:0]         rsp_count_now,
   output logic [6:0]         rsp_removed
);

   import bmh_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int WW = CW + 7;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RD,
      S_UP,
      S_UP_CHK,
      S_SCAN,
      S_SCAN_CHK,
      S_LAST,
      S_DN,
      S_DN_L,
      S_DN_R,
      S_RESP
   } state_type;

   state_type  state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] rem_ff, rem_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [AW-1:0] pos_ff, pos_in;
   value_type  cur_ff, cur_in;
   value_type  key_ff, key_in;
   value_type  lval_ff, lval_in;
   value_type  entry_ff, entry_in;
   status_type status_ff, status_in;
   logic       del_ff, del_in;
   logic       first_ff, first_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   value_type  rsp_entry_ff, rsp_entry_in;
   logic [6:0] rsp_count_ff, rsp_count_in;
   logic [6:0] rsp_removed_ff, rsp_removed_in;

   logic          ram_we, ram_re;
   logic [AW-1:0] ram_wa, ram_ra;
   logic [31:0]   ram_wd, ram_rd;
   value_type     rdata;

   logic [WW-1:0] cnt_w, rem_w, idx_w, pos_w, req_idx_w;
   logic [WW-1:0] left_w, right_w, parent_w;
   logic          l_gt;
   value_type     best_val;
   state_type     ret_state;

   bmh_ram #(
      .WIDTH (32),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   assign rdata     = ram_rd;
   assign cnt_w     = WW'(cnt_ff);
   assign rem_w     = WW'(rem_ff);
   assign idx_w     = WW'(idx_ff);
   assign pos_w     = WW'(pos_ff);
   assign req_idx_w = WW'(req_index);
   assign left_w    = (pos_w << 1) + WW'(1);
   assign right_w   = (pos_w << 1) + WW'(2);
   assign parent_w  = (pos_w - WW'(1)) >> 1;
   assign l_gt      = lval_ff > cur_ff;
   assign best_val  = l_gt ? lval_ff : cur_ff;
   // A delete goes back to the same slot after a sift; an insert is done.
   assign ret_state = del_ff ? S_SCAN : S_RESP;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      idx_in    = idx_ff;
      pos_in    = pos_ff;
      cur_in    = cur_ff;
      key_in    = key_ff;
      lval_in   = lval_ff;
      entry_in  = entry_ff;
      status_in = status_ff;
      del_in    = del_ff;
      first_in  = first_ff;

      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_entry_in   = rsp_entry_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_removed_in = rsp_removed_ff;

      ram_we = 1'b0;
      ram_wa = pos_ff;
      ram_wd = cur_ff;
      ram_re = 1'b0;
      ram_ra = pos_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               key_in    = req_value;
               rem_in    = '0;
               entry_in  = '0;
               status_in = ST_OK;
               del_in    = 1'b0;
               first_in  = 1'b0;
               state_in  = S_RESP;
               unique case (action_type'(req_action))
                  ACT_INSERT: begin
                     if (cnt_w >= WW'(CAPACITY)) begin
                        status_in = ST_FULL;
                     end else begin
                        pos_in   = AW'(cnt_ff);
                        cur_in   = req_value;
                        cnt_in   = cnt_ff + CW'(1);
                        state_in = S_UP;
                     end
                  end
                  ACT_DELETE: begin
                     del_in   = 1'b1;
                     idx_in   = '0;
                     state_in = S_SCAN;
                  end
                  ACT_READ: begin
                     if (req_idx_w < cnt_w) begin
                        ram_re   = 1'b1;
                        ram_ra   = AW'(req_idx_w);
                        state_in = S_RD;
                     end else begin
                        status_in = ST_RANGE;
                     end
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_RD: begin
            entry_in = rdata;
            state_in = S_RESP;
         end
         // The entry being sifted is held in cur_ff; its slot is written only
         // once it settles.
         S_UP: begin
            if (pos_ff == '0) begin
               ram_we   = 1'b1;
               state_in = ret_state;
            end else begin
               ram_re   = 1'b1;
               ram_ra   = AW'(parent_w);
               state_in = S_UP_CHK;
            end
         end
         S_UP_CHK: begin
            first_in = 1'b0;
            if (cur_ff > rdata) begin
               ram_we   = 1'b1;
               ram_wd   = rdata;
               pos_in   = AW'(parent_w);
               state_in = S_UP;
            end else if (first_ff) begin
               // The filler does not beat its parent, so it sifts down instead.
               state_in = S_DN;
            end else begin
               ram_we   = 1'b1;
               state_in = ret_state;
            end
         end
         S_SCAN: begin
            if (idx_w >= cnt_w) begin
               state_in = S_RESP;
            end else begin
               ram_re   = 1'b1;
               ram_ra   = idx_ff[AW-1:0];
               state_in = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            if (rdata != key_ff) begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_SCAN;
            end else begin
               cnt_in = cnt_ff - CW'(1);
               rem_in = rem_ff + CW'(1);
               if (idx_w == cnt_w - WW'(1)) begin
                  state_in = S_SCAN;
               end else begin
                  ram_re   = 1'b1;
                  ram_ra   = AW'(cnt_w - WW'(1));
                  state_in = S_LAST;
               end
            end
         end
         S_LAST: begin
            if (rdata == key_ff) begin
               // The filler matches too: put it in the hole and check it again.
               ram_we   = 1'b1;
               ram_wa   = idx_ff[AW-1:0];
               ram_wd   = rdata;
               state_in = S_SCAN;
            end else begin
               cur_in = rdata;
               pos_in = idx_ff[AW-1:0];
               if (idx_ff == '0) begin
                  state_in = S_DN;
               end else begin
                  first_in = 1'b1;
                  state_in = S_UP;
               end
            end
         end
         S_DN: begin
            if (left_w >= cnt_w) begin
               ram_we   = 1'b1;
               state_in = ret_state;
            end else begin
               ram_re   = 1'b1;
               ram_ra   = AW'(left_w);
               state_in = S_DN_L;
            end
         end
         S_DN_L: begin
            lval_in = rdata;
            if (right_w < cnt_w) begin
               ram_re   = 1'b1;
               ram_ra   = AW'(right_w);
               state_in = S_DN_R;
            end else if (rdata > cur_ff) begin
               ram_we   = 1'b1;
               ram_wd   = rdata;
               pos_in   = AW'(left_w);
               state_in = S_DN;
            end else begin
               ram_we   = 1'b1;
               state_in = ret_state;
            end
         end
         S_DN_R: begin
            ram_we = 1'b1;
            if (rdata > best_val) begin
               ram_wd   = rdata;
               pos_in   = AW'(right_w);
               state_in = S_DN;
            end else if (l_gt) begin
               ram_wd   = lval_ff;
               pos_in   = AW'(left_w);
               state_in = S_DN;
            end else begin
               state_in = ret_state;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_entry_in   = entry_ff;
               rsp_count_in   = cnt_w[6:0];
               rsp_removed_in = rem_w[6:0];
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rem_ff         <= rem_in;
      idx_ff         <= idx_in;
      pos_ff         <= pos_in;
      cur_ff         <= cur_in;
      key_ff         <= key_in;
      lval_ff        <= lval_in;
      entry_ff       <= entry_in;
      status_ff      <= status_in;
      del_ff         <= del_in;
      first_ff       <= first_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_entry_ff   <= rsp_entry_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_removed_ff <= rsp_removed_in;
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_value = rsp_entry_ff;
   assign rsp_count_now   = rsp_count_ff;
   assign rsp_removed     = rsp_removed_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_w <= WW'(CAPACITY))
      else $error("entry count exceeds capacity");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (ram_we && ram_re) |-> (ram_wa != ram_ra))
      else $error("RAM read and write to the same entry in one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != S_IDLE))
      else $error("accepted item did not start the sequencer");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN_CHK) |-> (idx_w < cnt_w))
      else $error("delete scan checks a slot beyond the count");

endmodule
